// ===== hdl/cvs_pkg.sv =====
// shared types, widths and codes for the column variance / std dev unit
`timescale 1ns / 1ps

package cvs_pkg;

    // sizing
    localparam int COLUMNS  = 32;
    localparam int MAX_ROWS = 1024;

    // field widths
    localparam int REQ_W    = 2;
    localparam int COL_W    = 5;
    localparam int SAMPLE_W = 24;
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 34;
    localparam int SQS_W    = 57;
    localparam int SQ_W     = 47;
    localparam int VAR_W    = 47;
    localparam int SD_W     = 24;

    // iterative datapath widths
    localparam int WIDE_W   = 68;
    localparam int ALU_W    = WIDE_W + 1;
    localparam int REM_W    = 25;
    localparam int STEP_W   = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic [COL_W-1:0]           col_index;
        logic signed [SAMPLE_W-1:0] sample_value;
    } cvs_req_t;

    typedef struct packed {
        logic [COL_W-1:0]           col_reported;
        logic [CNT_W-1:0]           sample_count;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [VAR_W-1:0]           variance_value;
        logic [SD_W-1:0]            std_dev_value;
        logic                       insufficient;
        logic                       overflow_seen;
    } cvs_res_t;

    // column totals handed to the statistics engine
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sum;
        logic [SQS_W-1:0]        sumsq;
    } cvs_operand_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [VAR_W-1:0]           variance;
        logic [SD_W-1:0]            std_dev;
    } cvs_stats_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cvs_eng_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_MUL,
        S_ADD_ACC,
        S_Q_READ,
        S_Q_RUN,
        S_Q_DONE
    } cvs_state_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_MUL_NSQ,
        E_MUL_SSQ,
        E_SUB,
        E_DIV_N1,
        E_DIV_N2,
        E_DIV_MEAN,
        E_MEAN_SIGN,
        E_SQRT,
        E_DONE
    } cvs_eng_state_t;

endpackage

// ===== hdl/cvs_stats_engine.sv =====
// iterative mean / variance / square root engine around one shared add-subtract unit
`timescale 1ns / 1ps

module cvs_stats_engine
    import cvs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cvs_operand_t    operand,
    output cvs_eng_status_t status,
    output cvs_stats_t      stats
);

    localparam logic [STEP_W-1:0] MUL_N_STEPS = STEP_W'(CNT_W);
    localparam logic [STEP_W-1:0] MUL_S_STEPS = STEP_W'(SUM_W);
    localparam logic [STEP_W-1:0] DIV_STEPS   = STEP_W'(WIDE_W);
    localparam logic [STEP_W-1:0] SQRT_STEPS  = STEP_W'(SD_W);

    cvs_eng_state_t state_reg, state_next;

    logic [CNT_W-1:0]           n_reg, n_next;
    logic [SUM_W-1:0]           smag_reg, smag_next;
    logic                       neg_reg, neg_next;
    logic [SQS_W-1:0]           sumsq_reg, sumsq_next;
    logic [WIDE_W-1:0]          acc_reg, acc_next;
    logic [WIDE_W-1:0]          num_reg, num_next;
    logic [WIDE_W-1:0]          dq_reg, dq_next;
    logic [SUM_W-1:0]           mplr_reg, mplr_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [SD_W-1:0]            root_reg, root_next;
    logic signed [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [VAR_W-1:0]           var_reg, var_next;
    logic [STEP_W-1:0]          cnt_reg, cnt_next;

    logic              last_step;
    logic [WIDE_W-1:0] alu_a;
    logic [WIDE_W-1:0] alu_b;
    logic              alu_sub;
    logic [ALU_W-1:0]  alu_res;
    logic              alu_neg;
    logic [WIDE_W-1:0] mcand;
    logic [WIDE_W-1:0] dq_shift;

    assign last_step = (cnt_reg == STEP_W'(1));

    // shared add-subtract unit, borrow in the top bit
    assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {ALU_W{alu_sub}}) + ALU_W'(alu_sub);
    assign alu_neg = alu_res[ALU_W-1];

    assign mcand    = (state_reg == E_MUL_NSQ) ? WIDE_W'(sumsq_reg) : WIDE_W'(smag_reg);
    assign dq_shift = {dq_reg[WIDE_W-2:0], ~alu_neg};

    // operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            E_MUL_NSQ, E_MUL_SSQ:
            begin
                alu_a = {acc_reg[WIDE_W-2:0], 1'b0};
                alu_b = mplr_reg[SUM_W-1] ? mcand : '0;
            end
            E_SUB:
            begin
                alu_a   = num_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            E_DIV_N1, E_DIV_N2, E_DIV_MEAN:
            begin
                alu_a   = WIDE_W'({rem_reg[CNT_W-1:0], dq_reg[WIDE_W-1]});
                alu_b   = WIDE_W'(n_reg);
                alu_sub = 1'b1;
            end
            E_MEAN_SIGN:
            begin
                alu_a   = '0;
                alu_b   = dq_reg;
                alu_sub = 1'b1;
            end
            E_SQRT:
            begin
                alu_a   = WIDE_W'({rem_reg, dq_reg[WIDE_W-1 -: 2]});
                alu_b   = WIDE_W'({root_reg, 2'b01});
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            E_IDLE:      if (start) state_next = E_MUL_NSQ;
            E_MUL_NSQ:   if (last_step) state_next = E_MUL_SSQ;
            E_MUL_SSQ:   if (last_step) state_next = E_SUB;
            E_SUB:       state_next = E_DIV_N1;
            E_DIV_N1:    if (last_step) state_next = E_DIV_N2;
            E_DIV_N2:    if (last_step) state_next = E_DIV_MEAN;
            E_DIV_MEAN:  if (last_step) state_next = E_MEAN_SIGN;
            E_MEAN_SIGN: state_next = E_SQRT;
            E_SQRT:      if (last_step) state_next = E_DONE;
            E_DONE:      state_next = E_IDLE;
            default:     state_next = E_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        n_next     = n_reg;
        smag_next  = smag_reg;
        neg_next   = neg_reg;
        sumsq_next = sumsq_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        dq_next    = dq_reg;
        mplr_next  = mplr_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        mean_next  = mean_reg;
        var_next   = var_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    n_next     = operand.n;
                    neg_next   = operand.sum[SUM_W-1];
                    smag_next  = operand.sum[SUM_W-1] ? SUM_W'(-operand.sum)
                                                      : SUM_W'(operand.sum);
                    sumsq_next = operand.sumsq;
                    acc_next   = '0;
                    mplr_next  = {operand.n, {(SUM_W-CNT_W){1'b0}}};
                    cnt_next   = MUL_N_STEPS;
                end
            end
            // n * sum of squares, multiplier bits msb first
            E_MUL_NSQ:
            begin
                acc_next  = alu_res[WIDE_W-1:0];
                mplr_next = {mplr_reg[SUM_W-2:0], 1'b0};
                cnt_next  = cnt_reg - STEP_W'(1);
                if (last_step)
                begin
                    num_next  = alu_res[WIDE_W-1:0];
                    acc_next  = '0;
                    mplr_next = smag_reg;
                    cnt_next  = MUL_S_STEPS;
                end
            end
            // sum squared
            E_MUL_SSQ:
            begin
                acc_next  = alu_res[WIDE_W-1:0];
                mplr_next = {mplr_reg[SUM_W-2:0], 1'b0};
                cnt_next  = cnt_reg - STEP_W'(1);
            end
            E_SUB:
            begin
                dq_next  = alu_res[WIDE_W-1:0];
                rem_next = '0;
                cnt_next = DIV_STEPS;
            end
            // restoring division by n; two passes give the quotient by n squared, a third gives the mean
            E_DIV_N1, E_DIV_N2, E_DIV_MEAN:
            begin
                rem_next = REM_W'(alu_neg ? alu_a[CNT_W-1:0] : alu_res[CNT_W-1:0]);
                dq_next  = dq_shift;
                cnt_next = cnt_reg - STEP_W'(1);
                if (last_step)
                begin
                    rem_next = '0;
                    cnt_next = DIV_STEPS;
                    if (state_reg == E_DIV_N2)
                    begin
                        var_next = dq_shift[VAR_W-1:0];
                        dq_next  = WIDE_W'(smag_reg);
                    end
                end
            end
            E_MEAN_SIGN:
            begin
                mean_next = neg_reg ? alu_res[SAMPLE_W-1:0] : dq_reg[SAMPLE_W-1:0];
                dq_next   = {1'b0, var_reg, {(WIDE_W-VAR_W-1){1'b0}}};
                rem_next  = '0;
                root_next = '0;
                cnt_next  = SQRT_STEPS;
            end
            // one root bit per step, two radicand bits enter
            E_SQRT:
            begin
                dq_next  = {dq_reg[WIDE_W-3:0], 2'b00};
                cnt_next = cnt_reg - STEP_W'(1);
                if (!alu_neg)
                begin
                    rem_next  = alu_res[REM_W-1:0];
                    root_next = {root_reg[SD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = alu_a[REM_W-1:0];
                    root_next = {root_reg[SD_W-2:0], 1'b0};
                end
            end
            E_DONE:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        smag_reg  <= smag_next;
        neg_reg   <= neg_next;
        sumsq_reg <= sumsq_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        dq_reg    <= dq_next;
        mplr_reg  <= mplr_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        mean_reg  <= mean_next;
        var_reg   <= var_next;
    end

    assign status.busy     = (state_reg != E_IDLE);
    assign status.done     = (state_reg == E_DONE);
    assign stats.mean      = mean_reg;
    assign stats.variance  = var_reg;
    assign stats.std_dev   = root_reg;

endmodule

// ===== hdl/column_variance_stddev_unit.sv =====
// top level: per-column sum / sum of squares / count stores, request sequencer, result register
`timescale 1ns / 1ps

// channel  | signals                      | word
// ---------+------------------------------+--------------------------------------------
// req      | req_valid, req_ready, req_data | add sample, query column or clear all
// res      | res_valid, res_ready, res_data | statistics of one queried column
//
// an add steps through accept, square and accumulate; a clear or an unused code is taken in the idle state alone
// a query with count above one waits on the engine, whose steps all run on the shared
//   add-subtract unit: 11 + 34 multiply steps, 3 x 68 division steps, 24 root steps
// a query with count of one or less skips the engine and goes from the read state to the hand-off state
// reset clears the valid and overflow marks, so every column reads as empty at once
// the result register lets adds and clears go on while a word waits on res_ready;
//   a finished query holds until that register is free

module column_variance_stddev_unit
    import cvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  cvs_req_t req_data,
    output logic     res_valid,
    input  logic     res_ready,
    output cvs_res_t res_data
);

    cvs_state_t state_reg, state_next;

    // request word held while it is worked on
    cvs_req_t req_reg;

    // column stores; an entry without its valid bit reads as zero
    logic signed [SUM_W-1:0] sum_store_reg [COLUMNS];
    logic [SQS_W-1:0]        sqs_store_reg [COLUMNS];
    logic [CNT_W-1:0]        cnt_store_reg [COLUMNS];
    logic [COLUMNS-1:0]      valid_reg;
    logic [COLUMNS-1:0]      ovf_reg;

    logic [SQ_W-1:0]         sq_reg, sq_next;
    cvs_res_t                res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    req_accept;
    logic [COL_W-1:0]        col;
    logic                    rd_valid;
    logic signed [SUM_W-1:0] rd_sum;
    logic [SQS_W-1:0]        rd_sqs;
    logic [CNT_W-1:0]        rd_cnt;
    logic                    col_full;
    logic                    enough;
    logic [SAMPLE_W-1:0]     mag;
    logic [2*SAMPLE_W-1:0]   mag_sq;

    // fsm outputs
    logic                    do_clear;
    logic                    store_wr;
    logic                    mark_ovf;
    logic                    eng_start;
    logic                    res_load;

    cvs_operand_t            eng_operand;
    cvs_eng_status_t         eng_status;
    cvs_stats_t              eng_stats;

    assign req_accept = req_valid && req_ready;
    assign col        = req_reg.col_index;

    // column readout
    assign rd_valid = valid_reg[col];
    assign rd_sum   = rd_valid ? sum_store_reg[col] : '0;
    assign rd_sqs   = rd_valid ? sqs_store_reg[col] : '0;
    assign rd_cnt   = rd_valid ? cnt_store_reg[col] : '0;
    assign col_full = (rd_cnt >= CNT_W'(MAX_ROWS));
    assign enough   = (rd_cnt > CNT_W'(1));

    // sample magnitude squared, registered before the accumulate
    assign mag    = req_reg.sample_value[SAMPLE_W-1] ? SAMPLE_W'(-req_reg.sample_value)
                                                     : SAMPLE_W'(req_reg.sample_value);
    assign mag_sq = mag * mag;
    assign sq_next = (state_reg == S_ADD_MUL) ? mag_sq[SQ_W-1:0] : sq_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    priority if (req_data.req_type == REQ_ADD)
                        state_next = S_ADD_MUL;
                    else if (req_data.req_type == REQ_QUERY)
                        state_next = S_Q_READ;
                    else
                        state_next = S_IDLE;
                end
            end
            S_ADD_MUL: state_next = S_ADD_ACC;
            S_ADD_ACC: state_next = S_IDLE;
            S_Q_READ:  state_next = enough ? S_Q_RUN : S_Q_DONE;
            S_Q_RUN:   if (eng_status.done) state_next = S_Q_DONE;
            S_Q_DONE:  if (!res_valid_reg || res_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_ready = 1'b0;
        do_clear  = 1'b0;
        store_wr  = 1'b0;
        mark_ovf  = 1'b0;
        eng_start = 1'b0;
        res_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                do_clear  = req_valid && (req_data.req_type == REQ_CLEAR);
            end
            S_ADD_ACC:
            begin
                // a full column drops the sample and keeps a sticky mark
                store_wr = !col_full;
                mark_ovf = col_full;
            end
            S_Q_READ:
            begin
                eng_start = enough;
            end
            S_Q_DONE:
            begin
                res_load = !res_valid_reg || res_ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign eng_operand.n     = rd_cnt;
    assign eng_operand.sum   = rd_sum;
    assign eng_operand.sumsq = rd_sqs;

    cvs_stats_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eng_start),
        .operand (eng_operand),
        .status  (eng_status),
        .stats   (eng_stats)
    );

    // result word; stores are steady during a query since no request is taken
    always_comb
    begin
        res_next = res_reg;
        if (res_load)
        begin
            res_next.col_reported   = col;
            res_next.sample_count   = rd_cnt;
            res_next.insufficient   = !enough;
            res_next.overflow_seen  = ovf_reg[col];
            res_next.mean_value     = enough ? eng_stats.mean : '0;
            res_next.variance_value = enough ? eng_stats.variance : '0;
            res_next.std_dev_value  = enough ? eng_stats.std_dev : '0;
        end
    end

    always_comb
    begin
        priority if (res_load)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
            ovf_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (do_clear)
            begin
                valid_reg <= '0;
                ovf_reg   <= '0;
            end
            else
            begin
                if (store_wr)
                    valid_reg[col] <= 1'b1;
                if (mark_ovf)
                    ovf_reg[col] <= 1'b1;
            end
        end
    end

    // payload and column stores
    always_ff @(posedge clk)
    begin
        if (req_accept)
            req_reg <= req_data;
        sq_reg  <= sq_next;
        res_reg <= res_next;
        if (store_wr)
        begin
            sum_store_reg[col] <= rd_sum + SUM_W'(req_reg.sample_value);
            sqs_store_reg[col] <= rd_sqs + SQS_W'(sq_reg);
            cnt_store_reg[col] <= rd_cnt + CNT_W'(1);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // engine only started when idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        eng_start |-> !eng_status.busy)
        else $error("engine started while busy");

    // engine completion only while a query waits on it
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.done |-> (state_reg == S_Q_RUN))
        else $error("engine done outside a query");

    // a new result word comes only from the query hand-off state
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_Q_DONE))
        else $error("result word raised outside a query");

    // std dev is the floor square root of the variance
    a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |->
            ((48'(res_reg.std_dev_value) * 48'(res_reg.std_dev_value))
                <= 48'(res_reg.variance_value)) &&
            (((48'(res_reg.std_dev_value) + 48'd1) * (48'(res_reg.std_dev_value) + 48'd1))
                > 48'(res_reg.variance_value)))
        else $error("std dev not floor square root of variance");

endmodule

// ===== sim/column_variance_stddev_unit_tb.sv =====
// self-checking testbench for the column variance / std dev unit, with its own statistics predictor
`timescale 1ns / 1ps

module column_variance_stddev_unit_tb;
    import cvs_pkg::*;

    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // random words after the directed list, in segments with fresh hot columns
    localparam int SEGMENTS     = 6;
    localparam int SEGMENT_LEN  = 150;
    // the tail wait is meant to cover one more query with data plus stalls
    localparam int SETTLE_CYCLES = 400;
    // about 3000 words in all; the limit is set well above their worst-case run
    localparam int LIMIT_CYCLES  = 6000000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    cvs_req_t req_data;
    logic     res_valid;
    logic     res_ready;
    cvs_res_t res_data;

    column_variance_stddev_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // one directed row: the request word and, where obvious, the statistics typed in
    typedef struct {
        cvs_req_t word;
        bit       typed;
        cvs_res_t want;
    } plan_row_t;

    plan_row_t plan_rows[$];

    // predicted statistics words still waiting for the block, oldest first
    cvs_res_t expected_stats[$];

    // predictor copy of the per-column totals
    longint      col_sum     [COLUMNS];
    logic [63:0] col_sqsum   [COLUMNS];
    int unsigned col_rows    [COLUMNS];
    bit          col_dropped [COLUMNS];

    int fault_count;
    int cycles;

    // when calm, a side runs without gaps until it flips back
    bit sender_calm;
    bit receiver_calm;

    // hot columns and a large base value for near-constant data, per segment
    logic [COL_W-1:0]    hot_cols[4];
    logic [SAMPLE_W-1:0] base_val;

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, so a hung handshake still ends the run
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("column_variance_stddev_unit test failed");
        $finish;
    end

    task automatic note_fault(input string line);
        fault_count++;
        $display("ERROR @%0t: %s", $realtime, line);
    endtask

    function automatic cvs_req_t make_word(input logic [REQ_W-1:0] req,
                                           input logic [COL_W-1:0] col,
                                           input logic [SAMPLE_W-1:0] val);
        cvs_req_t w;
        w.req_type     = req;
        w.col_index    = col;
        w.sample_value = val;
        return w;
    endfunction

    function automatic cvs_res_t stats_word(input logic [COL_W-1:0] col,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [SAMPLE_W-1:0] mean,
                                            input logic [VAR_W-1:0] spread,
                                            input logic [SD_W-1:0] sd,
                                            input logic insuf,
                                            input logic ovf);
        cvs_res_t r;
        r.col_reported   = col;
        r.sample_count   = cnt;
        r.mean_value     = mean;
        r.variance_value = spread;
        r.std_dev_value  = sd;
        r.insufficient   = insuf;
        r.overflow_seen  = ovf;
        return r;
    endfunction

    // floor square root, one result bit per pass from the top
    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [63:0] rt;
        logic [63:0] trial;
        rt = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = rt | (64'd1 << b);
            if (trial * trial <= x)
                rt = trial;
        end
        return rt[31:0];
    endfunction

    task automatic clear_totals();
        for (int c = 0; c < COLUMNS; c++)
        begin
            col_sum[c]     = 0;
            col_sqsum[c]   = '0;
            col_rows[c]    = 0;
            col_dropped[c] = 1'b0;
        end
    endtask

    // advance the predictor by one accepted word; has_res says a statistics word follows
    task automatic predict_stats(input cvs_req_t w, output bit has_res, output cvs_res_t r);
        longint       v;
        longint       quot;
        int unsigned  n;
        logic [127:0] smag;
        logic [127:0] num;
        logic [127:0] spread;
        int           c;
        c       = int'(w.col_index);
        has_res = 1'b0;
        r       = '0;
        case (w.req_type)
            REQ_ADD:
            begin
                v = $signed(w.sample_value);
                // a full column drops the sample and marks it
                if (col_rows[c] >= MAX_ROWS)
                    col_dropped[c] = 1'b1;
                else
                begin
                    col_sum[c]   += v;
                    col_sqsum[c] += 64'(v * v);
                    col_rows[c]++;
                end
            end
            REQ_QUERY:
            begin
                has_res = 1'b1;
                n = col_rows[c];
                r = stats_word(w.col_index, n[CNT_W-1:0], '0, '0, '0, 1'b1, col_dropped[c]);
                if (n > 1)
                begin
                    // exact n*sumsq - sum^2 over n^2, never negative
                    smag   = 128'(col_sum[c] < 0 ? -col_sum[c] : col_sum[c]);
                    num    = 128'(n) * 128'(col_sqsum[c]) - smag * smag;
                    spread = num / (128'(n) * 128'(n));
                    quot   = col_sum[c] / longint'(n);
                    r.insufficient   = 1'b0;
                    r.mean_value     = quot[SAMPLE_W-1:0];
                    r.variance_value = spread[VAR_W-1:0];
                    r.std_dev_value  = SD_W'(root_floor(64'(spread[VAR_W-1:0])));
                end
            end
            REQ_CLEAR:
                clear_totals();
            default:
                ; // unused code, nothing happens
        endcase
    endtask

    // present one word, hold it until accepted, then predict what it causes
    task automatic send_word(input cvs_req_t w, input bit typed, input cvs_res_t want);
        int       gap;
        bit       has_res;
        cvs_res_t predicted;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_stats(w, has_res, predicted);
        if (has_res)
            expected_stats.push_back(typed ? want : predicted);
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
    endtask

    // sender stops until every predicted word has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_stats.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input cvs_req_t w);
        plan_row_t row;
        row.word  = w;
        row.typed = 1'b0;
        row.want  = '0;
        plan_rows.push_back(row);
    endtask

    task automatic add_checked_row(input cvs_req_t w, input cvs_res_t want);
        plan_row_t row;
        row.word  = w;
        row.typed = 1'b1;
        row.want  = want;
        plan_rows.push_back(row);
    endtask

    // directed list: empty columns, a single sample, field extremes, negative means,
    // the ignored code and clear
    task automatic load_plan();
        add_row(make_word(REQ_CLEAR, 5'd0, 24'h000000));
        add_checked_row(make_word(REQ_QUERY, 5'd0, 24'h000000),
                        stats_word(5'd0, 11'd0, '0, '0, '0, 1'b1, 1'b0));
        add_checked_row(make_word(REQ_QUERY, 5'd31, 24'hFFFFFF),
                        stats_word(5'd31, 11'd0, '0, '0, '0, 1'b1, 1'b0));
        // one sample is not enough for statistics
        add_row(make_word(REQ_ADD, 5'd3, 24'h000100));
        add_checked_row(make_word(REQ_QUERY, 5'd3, 24'h000000),
                        stats_word(5'd3, 11'd1, '0, '0, '0, 1'b1, 1'b0));
        // 1.0 and 3.0: mean 2.0, variance 1.0, std dev 1.0
        add_row(make_word(REQ_ADD, 5'd3, 24'h000300));
        add_checked_row(make_word(REQ_QUERY, 5'd3, 24'h000000),
                        stats_word(5'd3, 11'd2, 24'h000200, 47'h10000, 24'h000100,
                                   1'b0, 1'b0));
        // widest spread the sample range allows
        add_row(make_word(REQ_ADD, 5'd5, 24'h7FFFFF));
        add_row(make_word(REQ_ADD, 5'd5, 24'h800000));
        add_row(make_word(REQ_QUERY, 5'd5, 24'h000000));
        // most negative mean, zero variance
        add_row(make_word(REQ_ADD, 5'd31, 24'h800000));
        add_row(make_word(REQ_ADD, 5'd31, 24'h800000));
        add_checked_row(make_word(REQ_QUERY, 5'd31, 24'h000000),
                        stats_word(5'd31, 11'd2, 24'h800000, '0, '0, 1'b0, 1'b0));
        add_row(make_word(REQ_ADD, 5'd6, 24'hFFFFFF));
        add_row(make_word(REQ_ADD, 5'd6, 24'h000002));
        add_row(make_word(REQ_ADD, 5'd6, 24'hFFFFFC));
        add_row(make_word(REQ_QUERY, 5'd6, 24'h000000));
        // unused code must leave column 6 alone
        add_row(make_word(REQ_UNUSED, 5'd6, 24'h123456));
        add_row(make_word(REQ_QUERY, 5'd6, 24'h000000));
        add_row(make_word(REQ_CLEAR, 5'd31, 24'hFFFFFF));
        add_checked_row(make_word(REQ_QUERY, 5'd5, 24'h000000),
                        stats_word(5'd5, 11'd0, '0, '0, '0, 1'b1, 1'b0));
        add_checked_row(make_word(REQ_QUERY, 5'd6, 24'h000000),
                        stats_word(5'd6, 11'd0, '0, '0, '0, 1'b1, 1'b0));
        // -1.5 in raw units truncates toward zero
        add_row(make_word(REQ_ADD, 5'd7, 24'hFFFFFF));
        add_row(make_word(REQ_ADD, 5'd7, 24'hFFFFFE));
        add_row(make_word(REQ_QUERY, 5'd7, 24'h000000));
    endtask

    // mix of full range, small, extreme and near-constant samples
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int style;
        style = $urandom_range(0, 9);
        if (style < 3)
            return SAMPLE_W'($urandom);
        if (style < 6)
            return SAMPLE_W'($urandom_range(0, 2047) - 1024);
        if (style == 6)
        begin
            case ($urandom_range(0, 3))
                0:       return 24'h7FFFFF;
                1:       return 24'h800000;
                2:       return 24'h000000;
                default: return 24'hFFFFFF;
            endcase
        end
        // large mean with a tiny spread
        return base_val + SAMPLE_W'($urandom_range(0, 63) - 32);
    endfunction

    // push one column past its row limit; queries around the edge see the count and mark
    task automatic fill_column(input logic [COL_W-1:0] col, input bit pinned);
        logic [SAMPLE_W-1:0] val;
        for (int i = 0; i < MAX_ROWS + 3; i++)
        begin
            if (i >= MAX_ROWS - 1 && i <= MAX_ROWS + 1)
                send_word(make_word(REQ_QUERY, col, SAMPLE_W'($urandom)), 1'b0, '0);
            // pinned at the most negative sample drives the sum to its extreme
            val = (pinned || $urandom_range(0, 1)) ? 24'h800000 : 24'h7FFFFF;
            send_word(make_word(REQ_ADD, col, val), 1'b0, '0);
        end
        send_word(make_word(REQ_QUERY, col, SAMPLE_W'($urandom)), 1'b0, '0);
    endtask

    // result side: check each accepted word, then stall for a drawn number of cycles
    initial
    begin : result_side
        int       stall;
        cvs_res_t want;
        res_ready    <= 1'b0;
        receiver_calm = 1'b0;
        stall         = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
            begin
                if (expected_stats.size() == 0)
                    note_fault($sformatf("result word for column %0d with no query waiting",
                                         res_data.col_reported));
                else
                begin
                    want = expected_stats.pop_front();
                    if (res_data.col_reported !== want.col_reported)
                        note_fault($sformatf("col_reported %0d, expected %0d",
                                             res_data.col_reported, want.col_reported));
                    if (res_data.sample_count !== want.sample_count)
                        note_fault($sformatf("col %0d sample_count %0d, expected %0d",
                                             want.col_reported, res_data.sample_count,
                                             want.sample_count));
                    if (res_data.mean_value !== want.mean_value)
                        note_fault($sformatf("col %0d mean_value %h, expected %h",
                                             want.col_reported, res_data.mean_value,
                                             want.mean_value));
                    if (res_data.variance_value !== want.variance_value)
                        note_fault($sformatf("col %0d variance_value %h, expected %h",
                                             want.col_reported, res_data.variance_value,
                                             want.variance_value));
                    if (res_data.std_dev_value !== want.std_dev_value)
                        note_fault($sformatf("col %0d std_dev_value %h, expected %h",
                                             want.col_reported, res_data.std_dev_value,
                                             want.std_dev_value));
                    if (res_data.insufficient !== want.insufficient)
                        note_fault($sformatf("col %0d insufficient %b, expected %b",
                                             want.col_reported, res_data.insufficient,
                                             want.insufficient));
                    if (res_data.overflow_seen !== want.overflow_seen)
                        note_fault($sformatf("col %0d overflow_seen %b, expected %b",
                                             want.col_reported, res_data.overflow_seen,
                                             want.overflow_seen));
                end
                stall = receiver_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 29) == 0)
                    receiver_calm = !receiver_calm;
            end
            // one assignment to ready per edge
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                stall--;
            end
            else
                res_ready <= 1'b1;
        end
    end

    // request side: reset, directed list, random segments with two column fills
    initial
    begin : request_side
        cvs_req_t w;
        int       counted;
        int       pick;
        req_valid  <= 1'b0;
        req_data   <= '0;
        rst_n      <= 1'b0;
        fault_count = 0;
        sender_calm = 1'b0;
        clear_totals();

        // reset held, then released once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_plan();
        foreach (plan_rows[i])
            send_word(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].want);
        drain_results();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            foreach (hot_cols[k])
                hot_cols[k] = COL_W'($urandom_range(0, COLUMNS - 1));
            base_val = SAMPLE_W'($urandom);
            counted  = 0;
            while (counted < SEGMENT_LEN)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    w = make_word(REQ_CLEAR, COL_W'($urandom), SAMPLE_W'($urandom));
                else if (pick < 5)
                    w = make_word(REQ_UNUSED, COL_W'($urandom), SAMPLE_W'($urandom));
                else if (pick < 18)
                    // mostly columns with data, sometimes any column
                    w = make_word(REQ_QUERY,
                                  ($urandom_range(0, 9) < 7)
                                      ? hot_cols[$urandom_range(0, 3)]
                                      : COL_W'($urandom_range(0, COLUMNS - 1)),
                                  SAMPLE_W'($urandom));
                else
                    w = make_word(REQ_ADD,
                                  ($urandom_range(0, 9) < 9)
                                      ? hot_cols[$urandom_range(0, 3)]
                                      : COL_W'($urandom_range(0, COLUMNS - 1)),
                                  draw_sample());
                send_word(w, 1'b0, '0);
                // ignored words do not count toward the segment
                if (w.req_type != REQ_UNUSED)
                    counted++;
            end

            // halfway: wait for everything, then fill two columns past the row limit
            if (seg == SEGMENTS / 2 - 1)
            begin
                drain_results();
                send_word(make_word(REQ_CLEAR, COL_W'($urandom), SAMPLE_W'($urandom)),
                          1'b0, '0);
                fill_column(hot_cols[0], 1'b1);
                fill_column(hot_cols[0] + 5'd1, 1'b0);
                // clear must also drop the overflow marks
                send_word(make_word(REQ_CLEAR, COL_W'($urandom), SAMPLE_W'($urandom)),
                          1'b0, '0);
                send_word(make_word(REQ_QUERY, hot_cols[0], SAMPLE_W'($urandom)), 1'b0, '0);
            end
            else if ($urandom_range(0, 1) == 0)
                drain_results();
        end

        // all words sent: wait for the last results, then watch for strays
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("column_variance_stddev_unit test passed");
        else
            $display("column_variance_stddev_unit test failed");
        $finish;
    end

endmodule
